/* rtl/core/xrec_pkg.sv */
`timescale 1ns / 1ps

package xrec_pkg;

  localparam int XREC_FRAC_BITS = 16;
  localparam int XREC_QW        = 32;  // quotient bits before saturation
  localparam int XREC_ROOT_W    = 32;  // square root result bits
  localparam int XREC_CFG_W     = 31;
  localparam int XREC_IDX_W     = 8;

  localparam logic [XREC_CFG_W-1:0] TIME_STEP_RST    = 31'd1092;
  localparam logic [XREC_CFG_W-1:0] COMPLIANCE_RST   = 31'd0;
  localparam logic [XREC_CFG_W-1:0] BODY_MASS_RST    = 31'd65536;
  localparam logic [XREC_CFG_W-1:0] BODY_INERTIA_RST = 31'd65536;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [XREC_IDX_W-1:0] {
    CFG_TIME_STEP    = 8'd0,
    CFG_COMPLIANCE   = 8'd1,
    CFG_BODY_MASS    = 8'd2,
    CFG_BODY_INERTIA = 8'd3
  } cfg_idx_t;

  // everything one item carries down the pipeline
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic        [31:0] ax;
    logic        [31:0] ay;
    logic               sh;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] lam;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] ang;
    logic        [30:0] pm;
    logic        [15:0] cnt;
    logic        [30:0] h;
    logic        [30:0] alpha;
    logic        [30:0] bm;
    logic        [30:0] bi;
    logic signed [31:0] h2;
    logic        [32:0] c;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] wp;
    logic signed [31:0] ib;
    logic signed [31:0] wb;
    logic signed [31:0] at;
    logic signed [31:0] wbs;
    logic signed [31:0] crn;
    logic signed [31:0] num;
    logic signed [31:0] f1;
    logic signed [31:0] s1;
    logic signed [31:0] den;
    logic signed [31:0] dl;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] mvx;
    logic signed [31:0] mvy;
    logic signed [31:0] ncx;
    logic signed [31:0] ncy;
    logic signed [31:0] cr2;
    logic signed [31:0] na;
    logic signed [63:0] pa;
    logic signed [63:0] pb;
    logic signed [63:0] pc;
    logic signed [63:0] pd;
    logic signed [63:0] pe;
    logic signed [63:0] pf;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(S32_MAX)) begin
      return S32_MAX;
    end else if (v < 66'(S32_MIN)) begin
      return S32_MIN;
    end
    return 32'(v);
  endfunction

  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p;
  endfunction

endpackage

/* rtl/core/xrec_div.sv */
`timescale 1ns / 1ps

// pipelined signed divider, one quotient bit per stage, saturating result
module xrec_div import xrec_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic        [SW-1:0] in_side,
  output logic                 out_valid,
  output logic signed [31:0]   quo,
  output logic        [SW-1:0] out_side
);

  localparam int QW = XREC_QW;
  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0] rem_r  [QW+1];
  logic [DW-1:0] dv_r   [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic [SW-1:0] side_r [QW+1];
  logic [QW:0]   neg_r;
  logic [QW:0]   ovf_r;
  logic [QW:0]   zero_r;
  logic [QW:0]   v_r;

  logic [NW-1:0] n_mag;
  logic [DW-1:0] d_mag;
  logic          ovf0;

  logic signed [31:0] quo_r;
  logic               ov_r;
  logic [SW-1:0]      oside_r;
  logic signed [31:0] quo_nxt;
  logic [QW-1:0]      qf;

  assign n_mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign d_mag = den[DW-1] ? DW'(-den) : DW'(den);
  assign ovf0  = (CW'(n_mag) >= (CW'(d_mag) << QW)) && (n_mag != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= n_mag;
      dv_r[0]   <= d_mag;
      q_r[0]    <= '0;
      side_r[0] <= in_side;
      neg_r[0]  <= num[NW-1] ^ den[DW-1];
      ovf_r[0]  <= ovf0;
      zero_r[0] <= (n_mag == '0);
    end
  end

  for (genvar g = 1; g <= QW; g++) begin : g_stage
    localparam int B = QW - g;
    logic [CW-1:0] dsh;
    logic          ge;
    assign dsh = CW'(dv_r[g-1]) << B;
    assign ge  = CW'(rem_r[g-1]) >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? NW'(CW'(rem_r[g-1]) - dsh) : rem_r[g-1];
        q_r[g]    <= q_r[g-1] | (ge ? (QW'(1) << B) : '0);
        dv_r[g]   <= dv_r[g-1];
        side_r[g] <= side_r[g-1];
        neg_r[g]  <= neg_r[g-1];
        ovf_r[g]  <= ovf_r[g-1];
        zero_r[g] <= zero_r[g-1];
      end
    end
  end

  assign qf = q_r[QW];

  always_comb begin
    if (zero_r[QW]) begin
      quo_nxt = '0;
    end else if (neg_r[QW]) begin
      quo_nxt = (ovf_r[QW] || (qf[31] && (qf[30:0] != '0))) ? S32_MIN : 32'(32'd0 - qf);
    end else begin
      quo_nxt = (ovf_r[QW] || qf[31]) ? S32_MAX : qf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[QW-1:0], in_valid};
      ov_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r   <= quo_nxt;
      oside_r <= side_r[QW];
    end
  end

  assign out_valid = ov_r;
  assign quo       = quo_r;
  assign out_side  = oside_r;

endmodule

/* rtl/core/xrec_isqrt.sv */
`timescale 1ns / 1ps

// pipelined floor square root, one root bit per stage
module xrec_isqrt import xrec_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [63:0]            rad,
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  output logic [XREC_ROOT_W-1:0] root,
  output logic [SW-1:0]          out_side
);

  localparam int RW = XREC_ROOT_W;

  logic [63:0]   rem_r  [RW+1];
  logic [RW-1:0] rt_r   [RW+1];
  logic [SW-1:0] side_r [RW+1];
  logic [RW:0]   v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rad;
      rt_r[0]   <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar g = 1; g <= RW; g++) begin : g_stage
    localparam int B = RW - g;
    logic [64:0] trial;
    logic        ge;
    assign trial = (65'(rt_r[g-1]) << (B + 1)) + (65'(1) << (2 * B));
    assign ge    = 65'(rem_r[g-1]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? 64'(65'(rem_r[g-1]) - trial) : rem_r[g-1];
        rt_r[g]   <= rt_r[g-1] | (ge ? (RW'(1) << B) : '0);
        side_r[g] <= side_r[g-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[RW-1:0], in_valid};
    end
  end

  assign out_valid = v_r[RW];
  assign root      = rt_r[RW];
  assign out_side  = side_r[RW];

endmodule

/* rtl/core/xpbd_rigid_elastic_contact.sv */
`timescale 1ns / 1ps

// throughput: one beat per cycle while the output is not stalled, set by the fully pipelined root and dividers
// a stalled output holds the whole pipeline, nothing is dropped or repeated
// reset (rst_n low, synchronous) empties the pipeline and loads the config defaults
module xpbd_rigid_elastic_contact import xrec_pkg::*; #(
  parameter int FRAC_BITS = XREC_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // elastic_x, elastic_y, anchor_x, anchor_y, arm_x, arm_y, particle_mass(31),
  // lambda_sum, com_x, com_y, angle, contact_count(16), one pad bit
  input  logic [367:0]          in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // lambda_delta, move_x, move_y, new_com_x, new_com_y, new_angle
  output logic [191:0]          out_tdata,
  input  logic                  cfg_we,
  input  logic [XREC_IDX_W-1:0] cfg_index,
  input  logic [XREC_CFG_W-1:0] cfg_data
);

  localparam int SW     = $bits(item_t);
  localparam int NW_N   = 34 + FRAC_BITS;     // separation shifted up
  localparam int NW_INV = 2 * FRAC_BITS + 2;  // one squared, for inverses
  localparam int NW_AT  = 32 + FRAC_BITS;     // compliance shifted up
  localparam int NW_DL  = 32 + FRAC_BITS;     // multiplier numerator shifted up
  localparam logic signed [NW_INV-1:0] ONE_SQ = NW_INV'(1) << (2 * FRAC_BITS);

  // configuration registers
  logic [XREC_CFG_W-1:0] time_step_r, compliance_r, body_mass_r, body_inertia_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r    <= TIME_STEP_RST;
      compliance_r   <= COMPLIANCE_RST;
      body_mass_r    <= BODY_MASS_RST;
      body_inertia_r <= BODY_INERTIA_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIME_STEP:    time_step_r    <= cfg_data;
        CFG_COMPLIANCE:   compliance_r   <= cfg_data;
        CFG_BODY_MASS:    body_mass_r    <= cfg_data;
        CFG_BODY_INERTIA: body_inertia_r <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // global stall: everything moves when the output beat is free or taken
  logic en;
  logic v17_r;
  assign en        = !v17_r || out_tready;
  assign in_tready = en;

  item_t r1_r, r1_nxt, r2_r, r2_nxt, r3_r, r3_nxt;
  item_t r5_r, r5_nxt, r6_r, r6_nxt, r7_r, r7_nxt, r8_r, r8_nxt;
  item_t r9_r, r9_nxt, r10_r, r10_nxt, r11_r, r11_nxt;
  item_t r12_r, r12_nxt, r13_r, r13_nxt, r14_r, r14_nxt;
  item_t r15_r, r15_nxt, r16_r, r16_nxt, r17_r, r17_nxt;
  logic  v1_r, v2_r, v3_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r;
  logic  v12_r, v13_r, v14_r, v15_r, v16_r;

  // entry: unpack the beat, take the separation and snapshot config
  always_comb begin
    r1_nxt       = '0;
    r1_nxt.dx    = 33'(signed'(in_tdata[31:0])) - 33'(signed'(in_tdata[95:64]));
    r1_nxt.dy    = 33'(signed'(in_tdata[63:32])) - 33'(signed'(in_tdata[127:96]));
    r1_nxt.rx    = signed'(in_tdata[159:128]);
    r1_nxt.ry    = signed'(in_tdata[191:160]);
    r1_nxt.pm    = in_tdata[222:192];
    r1_nxt.lam   = signed'(in_tdata[254:223]);
    r1_nxt.cx    = signed'(in_tdata[286:255]);
    r1_nxt.cy    = signed'(in_tdata[318:287]);
    r1_nxt.ang   = signed'(in_tdata[350:319]);
    r1_nxt.cnt   = in_tdata[366:351];
    r1_nxt.h     = time_step_r;
    r1_nxt.alpha = compliance_r;
    r1_nxt.bm    = body_mass_r;
    r1_nxt.bi    = body_inertia_r;
  end

  // magnitudes, halving when either side reaches 2^31, h squared
  logic [32:0]        abs_x, abs_y;
  logic signed [63:0] h_prod;
  assign abs_x  = r1_r.dx[32] ? 33'(-r1_r.dx) : 33'(r1_r.dx);
  assign abs_y  = r1_r.dy[32] ? 33'(-r1_r.dy) : 33'(r1_r.dy);
  assign h_prod = mul32(signed'({1'b0, r1_r.h}), signed'({1'b0, r1_r.h}));

  always_comb begin
    r2_nxt    = r1_r;
    r2_nxt.sh = abs_x[32] | abs_x[31] | abs_y[32] | abs_y[31];
    r2_nxt.ax = r2_nxt.sh ? abs_x[32:1] : abs_x[31:0];
    r2_nxt.ay = r2_nxt.sh ? abs_y[32:1] : abs_y[31:0];
    r2_nxt.h2 = sat32(66'(h_prod) >>> FRAC_BITS);
  end

  // squares of both halves, each below 2^62
  always_comb begin
    r3_nxt    = r2_r;
    r3_nxt.pa = mul32(signed'(r2_r.ax), signed'(r2_r.ax));
    r3_nxt.pb = mul32(signed'(r2_r.ay), signed'(r2_r.ay));
  end

  // separation length
  logic                   sq_v;
  logic [XREC_ROOT_W-1:0] sq_root;
  logic [SW-1:0]          sq_side;
  item_t                  sq_it;

  xrec_isqrt #(.SW(SW)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v3_r),
    .rad      (64'(r3_r.pa + r3_r.pb)),
    .in_side  (r3_r),
    .out_valid(sq_v),
    .root     (sq_root),
    .out_side (sq_side)
  );

  always_comb begin
    sq_it   = item_t'(sq_side);
    sq_it.c = sq_it.sh ? {sq_root, 1'b0} : {1'b0, sq_root};
  end

  // normal, inverse masses and the compliance term, all in parallel
  logic               b_v;
  logic [SW-1:0]      b_side;
  logic signed [31:0] b_nx, b_ny, b_wp, b_ib, b_wb, b_at;
  item_t              b_it;

  xrec_div #(.NW(NW_N), .DW(34), .SW(SW)) u_div_nx (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
    .num(NW_N'(sq_it.dx) <<< FRAC_BITS), .den(signed'({1'b0, sq_it.c})),
    .in_side(sq_it), .out_valid(b_v), .quo(b_nx), .out_side(b_side)
  );

  xrec_div #(.NW(NW_N), .DW(34), .SW(1)) u_div_ny (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
    .num(NW_N'(sq_it.dy) <<< FRAC_BITS), .den(signed'({1'b0, sq_it.c})),
    .in_side(1'b0), .out_valid(), .quo(b_ny), .out_side()
  );

  xrec_div #(.NW(NW_INV), .DW(32), .SW(1)) u_div_wp (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
    .num(ONE_SQ), .den(signed'({1'b0, sq_it.pm})),
    .in_side(1'b0), .out_valid(), .quo(b_wp), .out_side()
  );

  xrec_div #(.NW(NW_INV), .DW(32), .SW(1)) u_div_ib (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
    .num(ONE_SQ), .den(signed'({1'b0, sq_it.bi})),
    .in_side(1'b0), .out_valid(), .quo(b_ib), .out_side()
  );

  xrec_div #(.NW(NW_INV), .DW(32), .SW(1)) u_div_wb (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
    .num(ONE_SQ), .den(signed'({1'b0, sq_it.bm})),
    .in_side(1'b0), .out_valid(), .quo(b_wb), .out_side()
  );

  xrec_div #(.NW(NW_AT), .DW(32), .SW(1)) u_div_at (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_v),
    .num(NW_AT'(signed'({1'b0, sq_it.alpha})) <<< FRAC_BITS), .den(sq_it.h2),
    .in_side(1'b0), .out_valid(), .quo(b_at), .out_side()
  );

  always_comb begin
    b_it    = item_t'(b_side);
    b_it.nx = b_nx;
    b_it.ny = b_ny;
    b_it.wp = b_wp;
    b_it.ib = b_ib;
    b_it.wb = b_wb;
    b_it.at = b_at;
  end

  // body inverse mass shared among the contacts
  logic               c_v;
  logic [SW-1:0]      c_side;
  logic signed [31:0] c_wbs;

  xrec_div #(.NW(32), .DW(17), .SW(SW)) u_div_wbs (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_v),
    .num(b_it.wb), .den(signed'({1'b0, b_it.cnt})),
    .in_side(b_it), .out_valid(c_v), .quo(c_wbs), .out_side(c_side)
  );

  // cross products of arm and normal, compliance times multiplier
  always_comb begin
    r5_nxt     = item_t'(c_side);
    r5_nxt.wbs = c_wbs;
    r5_nxt.pa  = mul32(r5_nxt.rx, r5_nxt.ny);
    r5_nxt.pb  = mul32(r5_nxt.ry, r5_nxt.nx);
    r5_nxt.pc  = mul32(r5_nxt.at, r5_nxt.lam);
  end

  always_comb begin
    r6_nxt     = r5_r;
    r6_nxt.crn = sat32((66'(r5_r.pa) - 66'(r5_r.pb)) >>> FRAC_BITS);
    r6_nxt.num = sat32(-66'(signed'({1'b0, r5_r.c}))
                       - 66'(sat32(66'(r5_r.pc) >>> FRAC_BITS)));
  end

  // rotational term of the effective mass, two chained products
  always_comb begin
    r7_nxt    = r6_r;
    r7_nxt.pa = mul32(r6_r.ib, r6_r.crn);
  end

  always_comb begin
    r8_nxt    = r7_r;
    r8_nxt.f1 = sat32(66'(r7_r.pa) >>> FRAC_BITS);
  end

  always_comb begin
    r9_nxt    = r8_r;
    r9_nxt.pa = mul32(r8_r.f1, r8_r.crn);
  end

  always_comb begin
    r10_nxt    = r9_r;
    r10_nxt.s1 = sat32(66'(r9_r.wbs) + 66'(sat32(66'(r9_r.pa) >>> FRAC_BITS)));
  end

  // full denominator, each partial sum saturated
  always_comb begin
    r11_nxt     = r10_r;
    r11_nxt.den = sat32(66'(sat32(66'(r10_r.wp) + 66'(r10_r.s1))) + 66'(r10_r.at));
  end

  // multiplier change
  logic               d_v;
  logic [SW-1:0]      d_side;
  logic signed [31:0] d_dl;

  xrec_div #(.NW(NW_DL), .DW(32), .SW(SW)) u_div_dl (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v11_r),
    .num(NW_DL'(r11_r.num) <<< FRAC_BITS), .den(r11_r.den),
    .in_side(r11_r), .out_valid(d_v), .quo(d_dl), .out_side(d_side)
  );

  // impulse along the normal
  always_comb begin
    r12_nxt    = item_t'(d_side);
    r12_nxt.dl = d_dl;
    r12_nxt.pa = mul32(d_dl, r12_nxt.nx);
    r12_nxt.pb = mul32(d_dl, r12_nxt.ny);
  end

  always_comb begin
    r13_nxt    = r12_r;
    r13_nxt.px = sat32(66'(r12_r.pa) >>> FRAC_BITS);
    r13_nxt.py = sat32(66'(r12_r.pb) >>> FRAC_BITS);
  end

  // particle move, body shift and arm cross impulse
  always_comb begin
    r14_nxt    = r13_r;
    r14_nxt.pa = mul32(r13_r.wp, r13_r.px);
    r14_nxt.pb = mul32(r13_r.wp, r13_r.py);
    r14_nxt.pc = mul32(r13_r.px, r13_r.wb);
    r14_nxt.pd = mul32(r13_r.py, r13_r.wb);
    r14_nxt.pe = mul32(r13_r.rx, r13_r.py);
    r14_nxt.pf = mul32(r13_r.ry, r13_r.px);
  end

  always_comb begin
    r15_nxt     = r14_r;
    r15_nxt.mvx = sat32(66'(r14_r.pa) >>> FRAC_BITS);
    r15_nxt.mvy = sat32(66'(r14_r.pb) >>> FRAC_BITS);
    r15_nxt.ncx = sat32(66'(r14_r.cx) - 66'(sat32(66'(r14_r.pc) >>> FRAC_BITS)));
    r15_nxt.ncy = sat32(66'(r14_r.cy) - 66'(sat32(66'(r14_r.pd) >>> FRAC_BITS)));
    r15_nxt.cr2 = sat32((66'(r14_r.pe) - 66'(r14_r.pf)) >>> FRAC_BITS);
  end

  always_comb begin
    r16_nxt    = r15_r;
    r16_nxt.pa = mul32(r15_r.ib, r15_r.cr2);
  end

  // rotation with the half factor, then the coincident points bypass
  logic signed [31:0] dom;
  assign dom = sat32(66'(r16_r.pa) >>> FRAC_BITS) >>> 1;

  always_comb begin
    r17_nxt    = r16_r;
    r17_nxt.na = sat32(66'(r16_r.ang) - 66'(dom));
    if (r16_r.c == '0) begin
      r17_nxt.dl  = '0;
      r17_nxt.mvx = '0;
      r17_nxt.mvy = '0;
      r17_nxt.ncx = r16_r.cx;
      r17_nxt.ncy = r16_r.cy;
      r17_nxt.na  = r16_r.ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r  <= r1_nxt;
      r2_r  <= r2_nxt;
      r3_r  <= r3_nxt;
      r5_r  <= r5_nxt;
      r6_r  <= r6_nxt;
      r7_r  <= r7_nxt;
      r8_r  <= r8_nxt;
      r9_r  <= r9_nxt;
      r10_r <= r10_nxt;
      r11_r <= r11_nxt;
      r12_r <= r12_nxt;
      r13_r <= r13_nxt;
      r14_r <= r14_nxt;
      r15_r <= r15_nxt;
      r16_r <= r16_nxt;
      r17_r <= r17_nxt;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v5_r, v6_r, v7_r, v8_r, v9_r} <= '0;
      {v10_r, v11_r, v12_r, v13_r, v14_r, v15_r, v16_r, v17_r} <= '0;
    end else if (en) begin
      v1_r  <= in_tvalid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v5_r  <= c_v;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= d_v;
      v13_r <= v12_r;
      v14_r <= v13_r;
      v15_r <= v14_r;
      v16_r <= v15_r;
      v17_r <= v16_r;
    end
  end

  assign out_tvalid = v17_r;
  assign out_tdata  = {r17_r.na, r17_r.ncy, r17_r.ncx, r17_r.mvy, r17_r.mvx, r17_r.dl};

`ifndef ASSERT_OFF
  a_entry_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted beat did not reach the entry stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(v1_r) && $stable(v12_r) && out_tvalid))
    else $error("pipeline moved during an output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !v1_r && !v12_r))
    else $error("pipeline not empty after reset");
`endif

endmodule
